// ----- hw/rtl/md4_pkg.sv -----
// md4_pkg: shared types, constants and helper functions of the md4 hash engine
// used by the message buffer, the round unit and the top level
`default_nettype none

package md4_pkg;

   // initial chaining values and round constants
   localparam logic [31:0] IV_A     = 32'h67452301;
   localparam logic [31:0] IV_B     = 32'hefcdab89;
   localparam logic [31:0] IV_C     = 32'h98badcfe;
   localparam logic [31:0] IV_D     = 32'h10325476;
   localparam logic [31:0] K_ROUND2 = 32'h5A827999;
   localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam int unsigned COUNT_W   = 61;
   localparam int unsigned NUM_STEPS = 48;
   localparam logic [5:0]  LAST_POS  = 6'd63;
   localparam logic [5:0]  LEN_POS   = 6'd56;
   localparam logic [5:0]  LAST_STEP = 6'(NUM_STEPS - 1);
   localparam logic [1:0]  LAST_WORD = 2'd3;

   // round codes
   localparam logic [1:0] RND_F = 2'd0;
   localparam logic [1:0] RND_G = 2'd1;
   localparam logic [1:0] RND_H = 2'd2;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } md4_state_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic       init;
      logic       load;
      logic       step;
      logic       add;
      logic [5:0] step_idx;
   } md4_ctl_type;

   // message word used by one step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] i;
      logic [3:0] idx;
      i = step[3:0];
      case (step[5:4])
         RND_F:   idx = i;
         RND_G:   idx = {i[1:0], i[3:2]};
         default: idx = {i[0], i[1], i[2], i[3]};
      endcase
      return idx;
   endfunction

   // rotate amount of one step
   function automatic logic [4:0] shift_amt(input logic [5:0] step);
      logic [4:0] s;
      case ({step[5:4], step[1:0]})
         {RND_F, 2'd0}: s = 5'd3;
         {RND_F, 2'd1}: s = 5'd7;
         {RND_F, 2'd2}: s = 5'd11;
         {RND_F, 2'd3}: s = 5'd19;
         {RND_G, 2'd0}: s = 5'd3;
         {RND_G, 2'd1}: s = 5'd5;
         {RND_G, 2'd2}: s = 5'd9;
         {RND_G, 2'd3}: s = 5'd13;
         {RND_H, 2'd0}: s = 5'd3;
         {RND_H, 2'd1}: s = 5'd9;
         {RND_H, 2'd2}: s = 5'd11;
         default:       s = 5'd15;
      endcase
      return s;
   endfunction

   function automatic word_type round_k(input logic [1:0] rnd);
      word_type k;
      case (rnd)
         RND_F:   k = '0;
         RND_G:   k = K_ROUND2;
         default: k = K_ROUND3;
      endcase
      return k;
   endfunction

   function automatic word_type swap32(input word_type v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/md4_req_if.sv -----
// md4_req_if: message byte channel, valid/ready handshake
// no dependencies
`default_nettype none

interface md4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output msg_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input msg_byte, input has_byte, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/md4_rsp_if.sv -----
// md4_rsp_if: digest word channel, valid/ready handshake
// no dependencies
`default_nettype none

interface md4_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/md4_msg_buf.sv -----
// md4_msg_buf: 16 x 32-bit message block, written one byte at a time, one read port
// depends on md4_pkg
`default_nettype none

module md4_msg_buf (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [5:0]       wr_pos,
   input  wire logic [7:0]       wr_byte,
   input  wire logic [3:0]       rd_idx,
   output md4_pkg::word_type     rd_word
);
   import md4_pkg::*;

   word_type words_ff [16];

   // byte lane write, little-endian within the word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_pos[5:2]][wr_pos[1:0]*8 +: 8] <= wr_byte;
      end
   end

   assign rd_word = words_ff[rd_idx];

endmodule

`default_nettype wire

// ----- hw/rtl/md4_round_unit.sv -----
// md4_round_unit: chaining registers, working registers and the shared step datapath
// depends on md4_pkg
`default_nettype none

module md4_round_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire md4_pkg::md4_ctl_type ctl,
   input  wire md4_pkg::word_type  x_word,
   output md4_pkg::word_type       chain [4]
);
   import md4_pkg::*;

   word_type chain_ff [4];
   word_type chain_in [4];
   word_type work_ff  [4];
   word_type work_in  [4];

   logic [1:0]  rnd;
   word_type    f_val;
   word_type    sum;
   logic [63:0] rot_wide;
   word_type    rot;

   // boolean function of the current round
   always_comb begin
      rnd = ctl.step_idx[5:4];
      case (rnd)
         RND_F:   f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         RND_G:   f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                          (work_ff[2] & work_ff[3]);
         default: f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
      sum      = work_ff[0] + f_val + x_word + round_k(rnd);
      rot_wide = {sum, sum} << shift_amt(ctl.step_idx);
      rot      = rot_wide[63:32];
   end

   // working register update
   always_comb begin
      work_in = work_ff;
      if (ctl.load) begin
         work_in = chain_ff;
      end else if (ctl.step) begin
         work_in[0] = work_ff[3];
         work_in[1] = rot;
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
      end
   end

   // chaining register update
   always_comb begin
      chain_in = chain_ff;
      if (ctl.init) begin
         chain_in[0] = IV_A;
         chain_in[1] = IV_B;
         chain_in[2] = IV_C;
         chain_in[3] = IV_D;
      end else if (ctl.add) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain = chain_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/md4_hash_engine.sv -----
// md4_hash_engine: top level, byte gathering, padding sequencer and digest output
// depends on md4_pkg, md4_req_if, md4_rsp_if, md4_msg_buf, md4_round_unit
//
// Usage:
//   req_ch carries one item per transfer: msg_byte with has_byte set adds a
//   byte to the message; last ends the message after that item's byte, if any.
//   An item with has_byte and last both clear is taken and ignored.
//   rsp_ch returns four digest words (A, B, C, D, byte-swapped) after each
//   last item; digest_last marks the fourth.
// Timing:
//   bytes transfer one per cycle while the block buffer fills. The 64th byte
//   of a block starts a compression: the steps of the shared step unit, then
//   the chaining add, during which req_ch.ready is low.
//   On last, padding bytes are written one per cycle up to the end of the
//   block (64 minus the fill position), then the block is compressed; a
//   second padded block, likewise written and compressed, follows when the
//   0x80 marker falls at position 56 or later. The digest words then appear
//   one per cycle while rsp_ch.ready is high; a stalled receiver holds the
//   current word. New input is taken only after the fourth word transfers.
// Reset: synchronous; chaining values return to the MD4 initial values, the
//   byte count clears and the block returns to idle.
`default_nettype none

module md4_hash_engine (
   input  wire logic    clock,
   input  wire logic    reset,
   md4_req_if.sink      req_ch,
   md4_rsp_if.source    rsp_ch
);
   import md4_pkg::*;

   md4_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [5:0]         wp_ff, wp_in;
   logic [5:0]         step_ff, step_in;
   logic [1:0]         out_idx_ff, out_idx_in;
   logic               pad_first_ff, pad_first_in;
   logic               wrap_ff, wrap_in;
   logic               final_ff, final_in;
   logic               fin_pend_ff, fin_pend_in;

   md4_ctl_type        ctl;
   logic               wr_en;
   logic [5:0]         wr_pos;
   logic [7:0]         wr_byte;
   word_type           x_word;
   word_type           chain [4];

   logic               wrap_now;
   logic [63:0]        bit_len;
   logic [7:0]         pad_val;

   // padding byte: marker, zeros, then the little-endian bit length
   always_comb begin
      bit_len  = {cnt_ff, 3'b000};
      wrap_now = wrap_ff || (pad_first_ff && (wp_ff >= LEN_POS));
      if (pad_first_ff) begin
         pad_val = PAD_BYTE;
      end else if ((wp_ff >= LEN_POS) && !wrap_ff) begin
         pad_val = bit_len[wp_ff[2:0]*8 +: 8];
      end else begin
         pad_val = '0;
      end
   end

   // sequencer next state and controls
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      step_in      = step_ff;
      out_idx_in   = out_idx_ff;
      pad_first_in = pad_first_ff;
      wrap_in      = wrap_ff;
      final_in     = final_ff;
      fin_pend_in  = fin_pend_ff;
      ctl          = '0;
      ctl.step_idx = step_ff;
      wr_en        = 1'b0;
      wr_pos       = cnt_ff[5:0];
      wr_byte      = req_ch.msg_byte;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // ready is high here, so valid alone marks a transfer
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               step_in      = '0;
               pad_first_in = 1'b1;
               wrap_in      = 1'b0;
               final_in     = 1'b0;
               fin_pend_in  = req_ch.last;
               if (req_ch.has_byte) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  wp_in  = cnt_ff[5:0] + 1'b1;
                  if (cnt_ff[5:0] == LAST_POS) begin
                     ctl.load = 1'b1;
                     state_in = ST_ROUND;
                  end else if (req_ch.last) begin
                     state_in = ST_PAD;
                  end
               end else begin
                  wp_in = cnt_ff[5:0];
                  if (req_ch.last) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_ROUND: begin
            ctl.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctl.add = 1'b1;
            step_in = '0;
            if (final_ff) begin
               out_idx_in = '0;
               state_in   = ST_OUT;
            end else if (fin_pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            wr_en        = 1'b1;
            wr_pos       = wp_ff;
            wr_byte      = pad_val;
            wp_in        = wp_ff + 1'b1;
            pad_first_in = 1'b0;
            wrap_in      = wrap_now;
            if (wp_ff == LAST_POS) begin
               ctl.load = 1'b1;
               final_in = !wrap_now;
               wrap_in  = 1'b0;
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            // valid is high here, so ready alone marks a transfer
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               out_idx_in = out_idx_ff + 1'b1;
               if (out_idx_ff == LAST_WORD) begin
                  ctl.init    = 1'b1;
                  cnt_in      = '0;
                  fin_pend_in = 1'b0;
                  final_in    = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         step_ff      <= '0;
         out_idx_ff   <= '0;
         pad_first_ff <= 1'b0;
         wrap_ff      <= 1'b0;
         final_ff     <= 1'b0;
         fin_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         step_ff      <= step_in;
         out_idx_ff   <= out_idx_in;
         pad_first_ff <= pad_first_in;
         wrap_ff      <= wrap_in;
         final_ff     <= final_in;
         fin_pend_ff  <= fin_pend_in;
      end
   end

   // message block storage
   md4_msg_buf u_msg_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_pos  (wr_pos),
      .wr_byte (wr_byte),
      .rd_idx  (msg_index(step_ff)),
      .rd_word (x_word)
   );

   // shared step unit and chaining registers
   md4_round_unit u_round_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .x_word (x_word),
      .chain  (chain)
   );

   // digest word output
   assign rsp_ch.digest_word = swap32(chain[out_idx_ff]);
   assign rsp_ch.digest_last = (out_idx_ff == LAST_WORD);

endmodule

`default_nettype wire

// ----- hw/rtl/md4_checker.sv -----
// md4_checker: port-level assertions for md4_hash_engine, attached by bind
// depends on md4_hash_engine, md4_req_if, md4_rsp_if
`default_nettype none

module md4_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic        rsp_digest_last
);

   // no digest word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digest word valid right after reset");

   // input is never taken while digest words are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while digest output active");

   // a stalled digest word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word) &&
                                  $stable(rsp_digest_last))
      else $error("stalled digest word changed");

   // the four words follow each other without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_digest_last |=> rsp_valid)
      else $error("gap inside digest burst");

   // after the final word the block returns to taking input
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_digest_last |=> !rsp_valid && req_ready)
      else $error("block not idle after final digest word");

endmodule

bind md4_hash_engine md4_checker u_md4_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_digest_word (rsp_ch.digest_word),
   .rsp_digest_last (rsp_ch.digest_last)
);

`default_nettype wire

// ----- test/md4_digest_checker.sv -----
// md4_digest_checker: watches the byte and digest channels of md4_hash_engine,
// predicts every digest word and compares it; depends on md4_pkg, md4_req_if, md4_rsp_if
`default_nettype none

module md4_digest_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   md4_req_if          req_mon,
   md4_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import md4_pkg::*;

   typedef struct packed {
      word_type word;
      logic     last;
   } digest_beat_type;

   // rotate amounts per round, indexed by step mod 4
   localparam int unsigned SHIFT_F[4] = '{3, 7, 11, 19};
   localparam int unsigned SHIFT_G[4] = '{3, 5, 9, 13};
   localparam int unsigned SHIFT_H[4] = '{3, 9, 11, 15};

   digest_beat_type digest_q[$];
   digest_beat_type want;
   word_type        chain_val[4];
   logic [7:0]      blk_bytes[64];
   logic [60:0]     byte_total;

   function automatic word_type rotate_left(word_type v, int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void load_initial_chain();
      chain_val[0] = IV_A;
      chain_val[1] = IV_B;
      chain_val[2] = IV_C;
      chain_val[3] = IV_D;
   endfunction

   // three rounds of sixteen steps over the current block
   function automatic void compress_block();
      word_type    m[16];
      word_type    a, b, c, d, f, k, t;
      int unsigned idx, sh;
      int          w, r, i;
      for (w = 0; w < 16; w++) begin
         m[w] = {blk_bytes[4*w+3], blk_bytes[4*w+2], blk_bytes[4*w+1], blk_bytes[4*w]};
      end
      a = chain_val[0];
      b = chain_val[1];
      c = chain_val[2];
      d = chain_val[3];
      for (r = 0; r < 3; r++) begin
         for (i = 0; i < 16; i++) begin
            case (2'(r))
               RND_F: begin
                  f   = (b & c) | (~b & d);
                  idx = i;
                  k   = '0;
                  sh  = SHIFT_F[i % 4];
               end
               RND_G: begin
                  f   = (b & c) | (b & d) | (c & d);
                  idx = (i % 4) * 4 + i / 4;
                  k   = K_ROUND2;
                  sh  = SHIFT_G[i % 4];
               end
               default: begin
                  f   = b ^ c ^ d;
                  // bit-reversed step number
                  idx = {i[0], i[1], i[2], i[3]};
                  k   = K_ROUND3;
                  sh  = SHIFT_H[i % 4];
               end
            endcase
            t = rotate_left(a + f + m[idx] + k, sh);
            a = d;
            d = c;
            c = b;
            b = t;
         end
      end
      chain_val[0] += a;
      chain_val[1] += b;
      chain_val[2] += c;
      chain_val[3] += d;
   endfunction

   // one accepted item: gather the byte, pad and finish on last
   function automatic void absorb_item(logic [7:0] data, logic has, logic fin);
      int unsigned pos;
      logic [63:0] bit_len;
      int          n;
      if (has) begin
         pos            = byte_total[5:0];
         blk_bytes[pos] = data;
         byte_total     = byte_total + 1'b1;
         if (pos == LAST_POS) compress_block();
      end
      if (fin) begin
         pos            = byte_total[5:0];
         blk_bytes[pos] = PAD_BYTE;
         pos++;
         // marker too late for the length field: spill into an extra block
         if (pos > LEN_POS) begin
            while (pos < 64) begin
               blk_bytes[pos] = '0;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < LEN_POS) begin
            blk_bytes[pos] = '0;
            pos++;
         end
         bit_len = {byte_total, 3'b000};
         for (n = 0; n < 8; n++) blk_bytes[LEN_POS + n] = bit_len[8*n +: 8];
         compress_block();
         for (n = 0; n < 4; n++) begin
            digest_q.push_back('{swap32(chain_val[n]), (n == LAST_WORD)});
         end
         load_initial_chain();
         byte_total = '0;
      end
   endfunction

   // sample both channels at the edge where transfers happen
   always @(posedge clock) begin
      if (reset) begin
         load_initial_chain();
         byte_total = '0;
         digest_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest word, expected none actual %h last %b",
                        $time, rsp_mon.digest_word, rsp_mon.digest_last);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_mon.digest_word !== want.word) begin
                  $display("%0t: digest_word mismatch, expected %h actual %h",
                           $time, want.word, rsp_mon.digest_word);
                  fail_count++;
               end
               if (rsp_mon.digest_last !== want.last) begin
                  $display("%0t: digest_last mismatch, expected %b actual %b",
                           $time, want.last, rsp_mon.digest_last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_item(req_mon.msg_byte, req_mon.has_byte, req_mon.last);
         end
      end
      words_pending <= digest_q.size();
   end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: stimulus, receiver stalls and verdict for md4_hash_engine
// depends on md4_pkg, md4_req_if, md4_rsp_if, md4_hash_engine, md4_digest_checker
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_ALTERNATE,
      RX_RANDOM,
      RX_LONG_STALL
   } rx_mode_type;

   localparam int unsigned ITEM_GOAL     = 380;
   localparam int unsigned MSG_GOAL      = 12;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned TIMEOUT_NS    = 4_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned fail_count;
   int unsigned words_pending;
   int unsigned sent_items;
   int unsigned sent_msgs;
   int unsigned burst_left;

   rx_mode_type rx_mode;
   int unsigned rx_left;
   int unsigned rx_cycle;

   md4_req_if req_ch ();
   md4_rsp_if rsp_ch ();

   md4_hash_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   md4_digest_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one transfer on the byte channel; valid stays high for a following item
   task automatic send_item(logic [7:0] data, logic hb, logic lst);
      req_ch.valid    <= 1'b1;
      req_ch.msg_byte <= data;
      req_ch.has_byte <= hb;
      req_ch.last     <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (hb || lst) sent_items++;
   endtask

   // bursts of random length separated by random gaps
   task automatic send_paced(logic [7:0] data, logic hb, logic lst);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      send_item(data, hb, lst);
   endtask

   // hold off the sender until every digest word has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   // message of len bytes with occasional ignored items, last either on the final byte or on its own item
   task automatic send_message(int unsigned len, bit byte_on_last);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_paced(8'($urandom), 1'b0, 1'b0);
         send_paced(8'($urandom), 1'b1, byte_on_last && (i == len - 1));
      end
      if (!byte_on_last || len == 0) send_paced(8'($urandom), 1'b0, 1'b1);
      sent_msgs++;
   endtask

   // receiver ready, switching between stall patterns
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(50, 300);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_ALWAYS:     rsp_ch.ready <= 1'b1;
         RX_ALTERNATE:  rsp_ch.ready <= rx_cycle[0];
         RX_RANDOM:     rsp_ch.ready <= ($urandom_range(0, 9) < 6);
         RX_LONG_STALL: rsp_ch.ready <= ((rx_cycle % 23) >= 15);
         default:       rsp_ch.ready <= 1'b1;
      endcase
   end

   // stimulus and verdict
   initial begin
      int unsigned len, pick;
      req_ch.valid    <= 1'b0;
      req_ch.msg_byte <= '0;
      req_ch.has_byte <= 1'b0;
      req_ch.last     <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_paced(8'h00, 1'b0, 1'b1);
      // ignored item, then a single byte carried on the last item
      send_paced(8'hFF, 1'b0, 1'b0);
      send_paced(8'hFF, 1'b1, 1'b1);
      // byte extremes, last on an item of its own
      send_paced(8'h00, 1'b1, 1'b0);
      send_paced(8'h80, 1'b1, 1'b0);
      send_paced(8'h7F, 1'b1, 1'b0);
      send_paced(8'hFF, 1'b1, 1'b0);
      send_paced(8'hA5, 1'b0, 1'b1);
      // "abc", last with its final byte
      send_paced(8'h61, 1'b1, 1'b0);
      send_paced(8'h62, 1'b1, 1'b0);
      send_paced(8'h00, 1'b0, 1'b0);
      send_paced(8'h63, 1'b1, 1'b1);
      drain_results();

      // random messages, weighted toward short ones and padding boundaries
      sent_items = 0;
      while (sent_items < ITEM_GOAL || sent_msgs < MSG_GOAL) begin
         pick = $urandom_range(0, 7);
         if (pick < 4) begin
            len = $urandom_range(0, 8);
         end else if (pick < 6) begin
            case ($urandom_range(0, 7))
               0:       len = 55;
               1:       len = 56;
               2:       len = 57;
               3:       len = 63;
               4:       len = 64;
               5:       len = 65;
               6:       len = 119;
               default: len = 120;
            endcase
         end else begin
            len = $urandom_range(0, 100);
         end
         send_message(len, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 7) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
